// ===== src/ols_pkg.sv =====
// Shared types and constants for the ordered list store.
`timescale 1ns / 1ps
`default_nettype none

package ols_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int FUNC_W = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 7;
	localparam int LEN_W  = 7;
	localparam int STAT_W = 2;
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DEL_FIRST = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DEL_LAST  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] element;
		logic [LEN_W-1:0]        length;
		logic                    last;
	} res_t;

endpackage

`default_nettype wire

// ===== src/ols_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module ols_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ordered_list_store_unit.sv =====
// Top level of the ordered list store: command sequencer, element count and result register.
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of up to DEPTH signed 32-bit values kept in one simple dual-port RAM.
// Append, delete last, rejected commands and unused function codes finish in the idle state;
// their result is registered as the command is taken. Delete first and delete at position
// close the gap by moving the trailing elements one slot down, one element per cycle through
// the RAM's single read and write ports. Read out streams one element per cycle while the
// output is not stalled, from the registered RAM read data. A new command is taken only when
// the sequencer is idle and the result register is empty. The RAM needs no clearing after
// reset: only data from entries below the element count is ever used.
module ordered_list_store_unit
	import ols_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SHIFT = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              out_valid_q, out_valid_d;
	res_t              out_q, res_d;
	logic              res_load;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [VAL_W-1:0]  ram_wdata, ram_rdata;

	logic             accept, full, empty, pos_ok, emit_free, emit_last, shift_more;
	logic [CMP_W-1:0] pos_c, cnt_c, idx_c;

	ols_ram #(
		.DEPTH (DEPTH),
		.DATA_W(VAL_W),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		accept     = in_valid && in_ready;
		pos_c      = CMP_W'(in_data.position);
		cnt_c      = CMP_W'(cnt_q);
		idx_c      = CMP_W'(idx_q);
		full       = (cnt_c == CMP_W'(DEPTH));
		empty      = (cnt_q == '0);
		pos_ok     = (pos_c != '0) && (pos_c <= cnt_c);
		emit_free  = !out_valid_q || out_ready;
		emit_last  = (idx_c + CMP_W'(1)) == cnt_c;
		shift_more = (idx_c + CMP_W'(2)) < cnt_c;

		state_d     = state_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		out_valid_d = out_valid_q && !out_ready;
		res_load    = 1'b0;
		res_d       = '{status: STAT_OK, element: '0, length: LEN_W'(cnt_q), last: 1'b1};

		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(idx_c + CMP_W'(1));

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					unique case (in_data.func)
						FN_APPEND: begin
							if (full) begin
								res_d.status = STAT_FULL;
							end else begin
								ram_we       = 1'b1;
								ram_waddr    = ADDR_W'(cnt_q);
								ram_wdata    = in_data.value;
								cnt_d        = cnt_q + CNT_W'(1);
								res_d.length = LEN_W'(cnt_d);
							end
						end
						FN_DEL_FIRST: begin
							ram_re    = 1'b1;
							ram_raddr = ADDR_W'(1);
							idx_d     = '0;
							if (empty) begin
								res_d.status = STAT_EMPTY;
							end else if (cnt_c > CMP_W'(1)) begin
								res_load = 1'b0;
								state_d  = S_SHIFT;
							end else begin
								cnt_d        = cnt_q - CNT_W'(1);
								res_d.length = LEN_W'(cnt_d);
							end
						end
						FN_DEL_LAST: begin
							if (empty) begin
								res_d.status = STAT_EMPTY;
							end else begin
								cnt_d        = cnt_q - CNT_W'(1);
								res_d.length = LEN_W'(cnt_d);
							end
						end
						FN_DEL_POS: begin
							ram_re    = 1'b1;
							ram_raddr = ADDR_W'(in_data.position);
							idx_d     = ADDR_W'(pos_c - CMP_W'(1));
							if (!pos_ok) begin
								res_d.status = STAT_BADPOS;
							end else if (pos_c < cnt_c) begin
								res_load = 1'b0;
								state_d  = S_SHIFT;
							end else begin
								cnt_d        = cnt_q - CNT_W'(1);
								res_d.length = LEN_W'(cnt_d);
							end
						end
						FN_READ: begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							idx_d     = '0;
							if (empty) begin
								res_d.status = STAT_EMPTY;
							end else begin
								res_load = 1'b0;
								state_d  = S_EMIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT: begin
				// move the element one slot down, fetch the next one
				ram_we    = 1'b1;
				ram_re    = shift_more;
				ram_raddr = ADDR_W'(idx_c + CMP_W'(2));
				idx_d     = ADDR_W'(idx_c + CMP_W'(1));
				if (!shift_more) begin
					cnt_d        = cnt_q - CNT_W'(1);
					res_load     = 1'b1;
					res_d.length = LEN_W'(cnt_d);
					state_d      = S_IDLE;
				end
			end
			S_EMIT: begin
				// hold the read data until the result register frees up
				if (emit_free) begin
					res_load      = 1'b1;
					res_d.element = ram_rdata;
					res_d.last    = emit_last;
					if (emit_last) begin
						state_d = S_IDLE;
					end else begin
						ram_re = 1'b1;
						idx_d  = ADDR_W'(idx_c + CMP_W'(1));
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (res_load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.func == FN_APPEND && !full) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("append did not grow the list");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> ((idx_c + CMP_W'(1)) < cnt_c))
		else $error("shift source beyond the list end");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (idx_c < cnt_c))
		else $error("read out index beyond the list end");

endmodule

`default_nettype wire
